/* src/hbs_pkg.sv */
`timescale 1ns / 1ps
// hbs_pkg.sv: constants, codes and shared types of the height-map sampler.
// No dependencies; compile first.
package hbs_pkg;

    localparam int FRAC_W     = 16;
    localparam int COORD_W    = 17;
    localparam int INDEX_W    = 16;
    localparam int VALUE_W    = 32;
    localparam int CFG_W      = 11;
    localparam int CFG_ADDR_W = 1;
    localparam int OUT_W      = 48;

    localparam int IN_DATA_W  = 88;
    localparam int IDX_LSB    = 0;
    localparam int VAL_LSB    = IDX_LSB + INDEX_W;
    localparam int U_LSB      = VAL_LSB + VALUE_W;
    localparam int V_LSB      = U_LSB + COORD_W;

    localparam int HALF_TEXEL = 32768;

    localparam logic [CFG_W-1:0] DIM_RESET = 11'd256;

    localparam logic [CFG_ADDR_W-1:0] CFG_MAP_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAP_HEIGHT = 1'b1;

    localparam int OUT_DEPTH  = 4;
    localparam int OUT_PTR_W  = 2;
    localparam int CREDIT_W   = 3;

    localparam int SLOT_W = 2;
    localparam logic [SLOT_W-1:0] SLOT_FIRST = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_NEXT  = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_LAST  = 2'd3;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_SAMPLE = 1'b1
    } hbs_cmd_t;

    typedef struct packed {
        logic [FRAC_W-1:0] sx;
        logic [FRAC_W-1:0] sy;
    } hbs_wt_t;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
        hbs_wt_t           wt;
    } hbs_tag_t;

endpackage

/* src/hbs_addr.sv */
`timescale 1ns / 1ps
// hbs_addr.sv: two-stage front end; texel position, edge clamp and corner addresses.
// Depends on hbs_pkg.
module hbs_addr #(
    parameter int STORE_DEPTH = 65536,
    parameter int MAX_DIM     = 1024,
    parameter int HEIGHT_BITS = 32,
    localparam int ADDR_W     = $clog2(STORE_DEPTH),
    localparam int DIM_W      = $clog2(MAX_DIM + 1)
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  hbs_pkg::hbs_cmd_t                     in_cmd,
    input  logic [hbs_pkg::INDEX_W-1:0]           in_index,
    input  logic [hbs_pkg::VALUE_W-1:0]           in_value,
    input  logic [hbs_pkg::COORD_W-1:0]           in_u,
    input  logic [hbs_pkg::COORD_W-1:0]           in_v,
    input  logic [hbs_pkg::CFG_W-1:0]             map_width,
    input  logic [hbs_pkg::CFG_W-1:0]             map_height,
    output logic                                  op_valid,
    input  logic                                  op_ready,
    output hbs_pkg::hbs_cmd_t                     op_cmd,
    output logic [3:0][ADDR_W-1:0]                op_addr,
    output logic [HEIGHT_BITS-1:0]                op_wdata,
    output hbs_pkg::hbs_wt_t                      op_wt
);
    import hbs_pkg::*;

    localparam int P_W    = COORD_W + DIM_W;
    localparam int CELL_W = P_W - FRAC_W;
    localparam int IDX_W  = 2 * DIM_W;

    typedef struct packed {
        logic [DIM_W-1:0]  lo;
        logic [DIM_W-1:0]  hi;
        logic [FRAC_W-1:0] wt;
    } axis_t;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0)
            r = DIM_W'(1);
        else if (32'(d) > MAX_DIM)
            r = DIM_W'(MAX_DIM);
        else
            r = DIM_W'(d);
        return r;
    endfunction

    function automatic axis_t axis_of(input logic [COORD_W-1:0] coord,
                                      input logic [DIM_W-1:0]   dim);
        logic [P_W-1:0]    pos;
        logic [CELL_W-1:0] pos_int;
        logic [CELL_W-1:0] top;
        logic [CELL_W-1:0] lo;
        axis_t             r;
        pos     = P_W'(coord) * P_W'(dim) + P_W'(HALF_TEXEL);
        pos_int = pos[P_W-1:FRAC_W];
        top     = CELL_W'(dim) - CELL_W'(1);
        r.hi    = (pos_int < top) ? DIM_W'(pos_int) : DIM_W'(top);
        lo      = (pos_int == '0) ? '0 : pos_int - CELL_W'(1);
        r.lo    = (lo > top) ? DIM_W'(top) : DIM_W'(lo);
        r.wt    = pos[FRAC_W-1:0];
        return r;
    endfunction

    logic [DIM_W-1:0] eff_w;
    logic [DIM_W-1:0] eff_h;
    axis_t            ax_u;
    axis_t            ax_v;

    logic                   s1_valid_reg;
    hbs_cmd_t               s1_cmd_reg;
    logic [ADDR_W-1:0]      s1_waddr_reg;
    logic [HEIGHT_BITS-1:0] s1_wdata_reg;
    axis_t                  s1_ax_u_reg;
    axis_t                  s1_ax_v_reg;

    logic                   s2_valid_reg;
    hbs_cmd_t               s2_cmd_reg;
    logic [3:0][ADDR_W-1:0] s2_addr_reg;
    logic [HEIGHT_BITS-1:0] s2_wdata_reg;
    hbs_wt_t                s2_wt_reg;

    logic s1_ready;
    logic s2_ready;

    logic [IDX_W-1:0]       row_lo;
    logic [IDX_W-1:0]       row_hi;
    logic [3:0][ADDR_W-1:0] addr_next;

    assign eff_w = eff_dim(map_width);
    assign eff_h = eff_dim(map_height);
    assign ax_u  = axis_of(in_u, eff_w);
    assign ax_v  = axis_of(in_v, eff_h);

    assign s2_ready = !s2_valid_reg || op_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_comb
    begin
        row_lo = IDX_W'(s1_ax_v_reg.lo) * IDX_W'(eff_w);
        row_hi = IDX_W'(s1_ax_v_reg.hi) * IDX_W'(eff_w);
        addr_next[0] = ADDR_W'(row_lo + IDX_W'(s1_ax_u_reg.lo));
        addr_next[1] = ADDR_W'(row_lo + IDX_W'(s1_ax_u_reg.hi));
        addr_next[2] = ADDR_W'(row_hi + IDX_W'(s1_ax_u_reg.lo));
        addr_next[3] = ADDR_W'(row_hi + IDX_W'(s1_ax_u_reg.hi));
        if (s1_cmd_reg == CMD_WRITE)
        begin
            addr_next[0] = s1_waddr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_cmd_reg   <= in_cmd;
            s1_waddr_reg <= ADDR_W'(in_index);
            s1_wdata_reg <= HEIGHT_BITS'($signed(in_value));
            s1_ax_u_reg  <= ax_u;
            s1_ax_v_reg  <= ax_v;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_cmd_reg   <= s1_cmd_reg;
            s2_addr_reg  <= addr_next;
            s2_wdata_reg <= s1_wdata_reg;
            s2_wt_reg.sx <= s1_ax_u_reg.wt;
            s2_wt_reg.sy <= s1_ax_v_reg.wt;
        end
    end

    assign op_valid = s2_valid_reg;
    assign op_cmd   = s2_cmd_reg;
    assign op_addr  = s2_addr_reg;
    assign op_wdata = s2_wdata_reg;
    assign op_wt    = s2_wt_reg;

endmodule

/* src/hbs_store.sv */
`timescale 1ns / 1ps
// hbs_store.sv: single-port height memory, corner read sequencer and corner gather.
// Depends on hbs_pkg.
module hbs_store #(
    parameter int STORE_DEPTH = 65536,
    parameter int HEIGHT_BITS = 32,
    localparam int ADDR_W     = $clog2(STORE_DEPTH)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          op_valid,
    output logic                          op_ready,
    input  hbs_pkg::hbs_cmd_t             op_cmd,
    input  logic [3:0][ADDR_W-1:0]        op_addr,
    input  logic [HEIGHT_BITS-1:0]        op_wdata,
    input  hbs_pkg::hbs_wt_t              op_wt,
    input  logic                          room,
    output logic                          claim,
    output logic                          corner_valid,
    output logic [3:0][HEIGHT_BITS-1:0]   corners,
    output hbs_pkg::hbs_wt_t              corner_wt
);
    import hbs_pkg::*;

    logic [HEIGHT_BITS-1:0] mem [STORE_DEPTH];

    logic                   busy_reg;
    logic                   busy_next;
    logic [SLOT_W-1:0]      slot_reg;
    logic [SLOT_W-1:0]      slot_next;
    hbs_tag_t               tag_reg;
    hbs_tag_t               tag_next;
    logic [3:0][ADDR_W-1:0] addr_reg;
    hbs_wt_t                wt_reg;
    logic [HEIGHT_BITS-1:0] rd_data_reg;
    logic [HEIGHT_BITS-1:0] gather_reg [3];

    logic              take;
    logic              mem_en;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;

    assign op_ready = !busy_reg && (op_cmd == CMD_WRITE || room);
    assign take     = op_valid && op_ready;
    assign claim    = take && (op_cmd == CMD_SAMPLE);

    always_comb
    begin
        mem_en    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = op_addr[0];
        busy_next = busy_reg;
        slot_next = slot_reg;
        tag_next  = '0;
        if (busy_reg)
        begin
            mem_en         = 1'b1;
            mem_addr       = addr_reg[slot_reg];
            tag_next.valid = 1'b1;
            tag_next.slot  = slot_reg;
            tag_next.wt    = wt_reg;
            slot_next      = slot_reg + SLOT_W'(1);
            if (slot_reg == SLOT_LAST)
                busy_next = 1'b0;
        end
        else if (take)
        begin
            mem_en = 1'b1;
            if (op_cmd == CMD_WRITE)
            begin
                mem_we = 1'b1;
            end
            else
            begin
                tag_next.valid = 1'b1;
                tag_next.slot  = SLOT_FIRST;
                tag_next.wt    = op_wt;
                busy_next      = 1'b1;
                slot_next      = SLOT_NEXT;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_en)
        begin
            if (mem_we)
                mem[mem_addr] <= op_wdata;
            else
                rd_data_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            slot_reg <= SLOT_FIRST;
            tag_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            slot_reg <= slot_next;
            tag_reg  <= tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (claim)
        begin
            addr_reg <= op_addr;
            wt_reg   <= op_wt;
        end
        if (tag_reg.valid && tag_reg.slot != SLOT_LAST)
            gather_reg[tag_reg.slot] <= rd_data_reg;
    end

    assign corner_valid = tag_reg.valid && (tag_reg.slot == SLOT_LAST);
    assign corners      = {rd_data_reg, gather_reg[2], gather_reg[1], gather_reg[0]};
    assign corner_wt    = tag_reg.wt;

endmodule

/* src/hbs_lerp.sv */
`timescale 1ns / 1ps
// hbs_lerp.sv: three-stage interpolation pipeline, result queue and result credits.
// Depends on hbs_pkg.
module hbs_lerp #(
    parameter int HEIGHT_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          corner_valid,
    input  logic [3:0][HEIGHT_BITS-1:0]   corners,
    input  hbs_pkg::hbs_wt_t              corner_wt,
    input  logic                          claim,
    output logic                          room,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [hbs_pkg::OUT_W-1:0]     out_data
);
    import hbs_pkg::*;

    localparam int D_W  = HEIGHT_BITS + 1;
    localparam int M_W  = HEIGHT_BITS + 18;
    localparam int R_W  = HEIGHT_BITS + 19;
    localparam int DR_W = HEIGHT_BITS + 20;
    localparam int P_W  = DR_W + FRAC_W + 1;

    logic signed [HEIGHT_BITS-1:0] h00;
    logic signed [HEIGHT_BITS-1:0] h10;
    logic signed [HEIGHT_BITS-1:0] h01;
    logic signed [HEIGHT_BITS-1:0] h11;
    logic signed [D_W-1:0]         d0;
    logic signed [D_W-1:0]         d1;
    logic signed [R_W-1:0]         r0;
    logic signed [R_W-1:0]         r1;
    logic signed [DR_W-1:0]        dr;
    logic signed [P_W-1:0]         sum;

    logic                          l1_valid_reg;
    logic signed [HEIGHT_BITS-1:0] l1_h00_reg;
    logic signed [HEIGHT_BITS-1:0] l1_h01_reg;
    logic signed [M_W-1:0]         l1_m0_reg;
    logic signed [M_W-1:0]         l1_m1_reg;
    logic [FRAC_W-1:0]             l1_sy_reg;

    logic                          l2_valid_reg;
    logic signed [R_W-1:0]         l2_r0_reg;
    logic signed [R_W-1:0]         l2_r1_reg;
    logic [FRAC_W-1:0]             l2_sy_reg;

    logic                          l3_valid_reg;
    logic signed [R_W-1:0]         l3_r0_reg;
    logic signed [P_W-1:0]         l3_prod_reg;

    logic [OUT_W-1:0]     fifo_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg;
    logic [OUT_PTR_W-1:0] rd_ptr_reg;
    logic [CREDIT_W-1:0]  count_reg;
    logic [CREDIT_W-1:0]  credit_reg;
    logic                 push;
    logic                 pop;

    always_comb
    begin
        h00 = $signed(corners[0]);
        h10 = $signed(corners[1]);
        h01 = $signed(corners[2]);
        h11 = $signed(corners[3]);
        d0  = D_W'(h10) - D_W'(h00);
        d1  = D_W'(h11) - D_W'(h01);
        r0  = (R_W'(l1_h00_reg) <<< FRAC_W) + R_W'(l1_m0_reg);
        r1  = (R_W'(l1_h01_reg) <<< FRAC_W) + R_W'(l1_m1_reg);
        dr  = DR_W'(l2_r1_reg) - DR_W'(l2_r0_reg);
        sum = P_W'(l3_r0_reg) + (l3_prod_reg >>> FRAC_W);
    end

    assign push      = l3_valid_reg;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_data  = fifo_reg[rd_ptr_reg];
    assign room      = (credit_reg < CREDIT_W'(OUT_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_valid_reg <= 1'b0;
            l2_valid_reg <= 1'b0;
            l3_valid_reg <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
            credit_reg   <= '0;
        end
        else
        begin
            l1_valid_reg <= corner_valid;
            l2_valid_reg <= l1_valid_reg;
            l3_valid_reg <= l2_valid_reg;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + OUT_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + OUT_PTR_W'(1);
            count_reg  <= count_reg + CREDIT_W'(push) - CREDIT_W'(pop);
            credit_reg <= credit_reg + CREDIT_W'(claim) - CREDIT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (corner_valid)
        begin
            l1_h00_reg <= h00;
            l1_h01_reg <= h01;
            l1_m0_reg  <= M_W'(d0) * M_W'($signed({1'b0, corner_wt.sx}));
            l1_m1_reg  <= M_W'(d1) * M_W'($signed({1'b0, corner_wt.sx}));
            l1_sy_reg  <= corner_wt.sy;
        end
        if (l1_valid_reg)
        begin
            l2_r0_reg <= r0;
            l2_r1_reg <= r1;
            l2_sy_reg <= l1_sy_reg;
        end
        if (l2_valid_reg)
        begin
            l3_r0_reg   <= l2_r0_reg;
            l3_prod_reg <= P_W'(dr) * P_W'($signed({1'b0, l2_sy_reg}));
        end
        if (push)
            fifo_reg[wr_ptr_reg] <= OUT_W'(sum);
    end

endmodule

/* src/heightmap_bilinear_sampler.sv */
`timescale 1ns / 1ps
// heightmap_bilinear_sampler.sv: top level; configuration registers and stream ports.
// Depends on hbs_pkg, hbs_addr, hbs_store, hbs_lerp.
//
// Input stream (s_*): each item is either a height write (tuser = write) that
// stores one signed word at a row-major index and yields nothing, or a sample
// (tuser = sample) that carries u and v and yields one interpolated height on
// the output stream (m_*), in the order the samples came in.
// Configuration: cfg_we writes map_width (index 0) or map_height (index 1);
// write them only while no item is in flight.
// Throughput: one memory port serves everything. A write item holds it for one
// access, a sample for one read per corner, so the next sample waits for the last
// corner read; writes run at one per cycle while the port is free.
// A sample passes the front-end stages, the corner reads, the interpolation
// stages and the result queue before it shows on m_tvalid.
// The store size STORE_DEPTH must be a power of two, which the block does not check; indices wrap at that size.
// Reset clears the pipeline, the result queue and sets both dimensions to 256;
// the height memory keeps no reset value. When m_tready stays low, up to four
// results wait in the queue, then the read sequencer holds and s_tready drops.
module heightmap_bilinear_sampler #(
    parameter int STORE_DEPTH = 65536,
    parameter int MAX_DIM     = 1024,
    parameter int HEIGHT_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // texel_index[15:0], height_value[47:16], u_coord[64:48], v_coord[81:65], zero pad
    input  logic [hbs_pkg::IN_DATA_W-1:0]       s_tdata,
    // cmd[0]
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // height_result[47:0]
    output logic [hbs_pkg::OUT_W-1:0]           m_tdata,
    input  logic                                cfg_we,
    input  logic [hbs_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [hbs_pkg::CFG_W-1:0]           cfg_wdata
);
    import hbs_pkg::*;

    localparam int ADDR_W = $clog2(STORE_DEPTH);

    logic [CFG_W-1:0] map_width_reg;
    logic [CFG_W-1:0] map_height_reg;

    logic                        op_valid;
    logic                        op_ready;
    hbs_cmd_t                    op_cmd;
    logic [3:0][ADDR_W-1:0]      op_addr;
    logic [HEIGHT_BITS-1:0]      op_wdata;
    hbs_wt_t                     op_wt;
    logic                        room;
    logic                        claim;
    logic                        corner_valid;
    logic [3:0][HEIGHT_BITS-1:0] corners;
    hbs_wt_t                     corner_wt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= DIM_RESET;
            map_height_reg <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_MAP_WIDTH:  map_width_reg  <= cfg_wdata;
                CFG_MAP_HEIGHT: map_height_reg <= cfg_wdata;
                default:        map_width_reg  <= map_width_reg;
            endcase
        end
    end

    hbs_addr #(
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_DIM     (MAX_DIM),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_addr (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (hbs_cmd_t'(s_tuser[0])),
        .in_index   (s_tdata[IDX_LSB +: INDEX_W]),
        .in_value   (s_tdata[VAL_LSB +: VALUE_W]),
        .in_u       (s_tdata[U_LSB +: COORD_W]),
        .in_v       (s_tdata[V_LSB +: COORD_W]),
        .map_width  (map_width_reg),
        .map_height (map_height_reg),
        .op_valid   (op_valid),
        .op_ready   (op_ready),
        .op_cmd     (op_cmd),
        .op_addr    (op_addr),
        .op_wdata   (op_wdata),
        .op_wt      (op_wt)
    );

    hbs_store #(
        .STORE_DEPTH (STORE_DEPTH),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .op_valid     (op_valid),
        .op_ready     (op_ready),
        .op_cmd       (op_cmd),
        .op_addr      (op_addr),
        .op_wdata     (op_wdata),
        .op_wt        (op_wt),
        .room         (room),
        .claim        (claim),
        .corner_valid (corner_valid),
        .corners      (corners),
        .corner_wt    (corner_wt)
    );

    hbs_lerp #(
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_lerp (
        .clk          (clk),
        .rst_n        (rst_n),
        .corner_valid (corner_valid),
        .corners      (corners),
        .corner_wt    (corner_wt),
        .claim        (claim),
        .room         (room),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_data     (m_tdata)
    );

endmodule

/* src/hbs_checker.sv */
`timescale 1ns / 1ps
// hbs_checker.sv: port-level checks of the sampler, bound to the top level.
// Depends on hbs_pkg and heightmap_bilinear_sampler.
module hbs_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic [0:0]                 s_tuser,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [hbs_pkg::OUT_W-1:0]  m_tdata
);
    import hbs_pkg::*;

    localparam int MAX_PENDING = OUT_DEPTH + 2;
    localparam int PEND_W      = 4;

    logic [PEND_W-1:0] pending_reg;
    logic              sample_in;
    logic              result_out;

    assign sample_in  = s_tvalid && s_tready && (s_tuser[0] == CMD_SAMPLE);
    assign result_out = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_reg + PEND_W'(sample_in) - PEND_W'(result_out);
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result offered during reset");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pending_reg != '0)
        else $error("result offered with no sample outstanding");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= PEND_W'(MAX_PENDING))
        else $error("more samples in flight than the pipeline holds");

endmodule

bind heightmap_bilinear_sampler hbs_checker u_hbs_checker (.*);

/* test/tb.sv */
`timescale 1ns / 1ps
// tb.sv: self-checking testbench for heightmap_bilinear_sampler; it mirrors the
// height store, predicts every interpolated height and checks the output stream.
// Depends on hbs_pkg and the sampler RTL.
module tb;
    import hbs_pkg::*;

    localparam int MAP_MAX_DIM   = 1024;
    localparam int MAP_DEPTH     = 65536;
    localparam int MAP_BITS      = 32;
    localparam int SETTLE_CYCLES = 24;
    localparam int LONG_HOLD     = 300;
    localparam longint WATCHDOG_NS = 64'd12 * 64'd800000;

    typedef struct packed {
        hbs_cmd_t             cmd;
        logic [INDEX_W-1:0]   idx;
        logic [VALUE_W-1:0]   val;
        logic [COORD_W-1:0]   u;
        logic [COORD_W-1:0]   v;
    } hbs_item_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic [0:0]             s_tuser = CMD_WRITE;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_W-1:0]       m_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = CFG_MAP_WIDTH;
    logic [CFG_W-1:0]       cfg_wdata = '0;

    hbs_item_t              item_backlog[$];
    logic [OUT_W-1:0]       expected_heights[$];
    hbs_item_t              offered_item;
    logic signed [VALUE_W-1:0] height_mirror [0:MAP_DEPTH-1];
    bit                     loaded_texels [0:MAP_DEPTH-1];
    logic [CFG_W-1:0]       cur_width = DIM_RESET;
    logic [CFG_W-1:0]       cur_height = DIM_RESET;

    bit  send_idle_on = 1'b1;
    bit  recv_idle_on = 1'b1;
    int  send_gap = 0;
    int  hold_left = 0;
    int  long_hold_ask = 0;
    int  long_hold_seen = 0;
    int  queued_total = 0;
    int  writes_seen = 0;
    int  samples_seen = 0;
    int  results_checked = 0;
    int  dim_settings = 1;
    int  error_count = 0;

    heightmap_bilinear_sampler #(
        .STORE_DEPTH (MAP_DEPTH),
        .MAX_DIM     (MAP_MAX_DIM),
        .HEIGHT_BITS (MAP_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(WATCHDOG_NS);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int unsigned eff_dim(input logic [CFG_W-1:0] d);
        if (d == 0)
            return 1;
        if (d > MAP_MAX_DIM)
            return MAP_MAX_DIM;
        return d;
    endfunction

    // Low and high corner along one axis plus the 16-bit weight.
    function automatic void locate(input logic [COORD_W-1:0] coord, input int unsigned dim,
                                   output int unsigned lo, output int unsigned hi,
                                   output int unsigned frac);
        longint unsigned pos;
        longint unsigned upper;
        pos = longint'(coord) * dim + HALF_TEXEL;
        upper = pos >> FRAC_W;
        hi = (upper < dim - 1) ? upper : dim - 1;
        lo = (upper == 0) ? 0 : upper - 1;
        if (lo > dim - 1)
            lo = dim - 1;
        frac = pos & 64'hFFFF;
    endfunction

    // Corner order: (x0,y0), (x1,y0), (x0,y1), (x1,y1).
    function automatic void locate_corners(input logic [COORD_W-1:0] u,
                                           input logic [COORD_W-1:0] v,
                                           output logic [3:0][INDEX_W-1:0] at,
                                           output int unsigned sx, output int unsigned sy);
        int unsigned w, h, x0, x1, y0, y1;
        w = eff_dim(cur_width);
        h = eff_dim(cur_height);
        locate(u, w, x0, x1, sx);
        locate(v, h, y0, y1, sy);
        at[0] = INDEX_W'(y0 * w + x0);
        at[1] = INDEX_W'(y0 * w + x1);
        at[2] = INDEX_W'(y1 * w + x0);
        at[3] = INDEX_W'(y1 * w + x1);
    endfunction

    function automatic logic [OUT_W-1:0] bilerp_height(input logic [COORD_W-1:0] u,
                                                       input logic [COORD_W-1:0] v);
        logic [3:0][INDEX_W-1:0] at;
        int unsigned sx, sy;
        logic signed [95:0] h00, h10, h01, h11, wx, wy, r0, r1, sum;
        locate_corners(u, v, at, sx, sy);
        h00 = height_mirror[at[0]];
        h10 = height_mirror[at[1]];
        h01 = height_mirror[at[2]];
        h11 = height_mirror[at[3]];
        wx = sx;
        wy = sy;
        r0 = (h00 <<< FRAC_W) + (h10 - h00) * wx;
        r1 = (h01 <<< FRAC_W) + (h11 - h01) * wx;
        sum = r0 + (((r1 - r0) * wy) >>> FRAC_W);
        return sum[OUT_W-1:0];
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_item(input hbs_item_t it);
        logic [IN_DATA_W-1:0] d;
        d = '0;
        d[IDX_LSB +: INDEX_W] = it.idx;
        d[VAL_LSB +: VALUE_W] = it.val;
        d[U_LSB +: COORD_W]   = it.u;
        d[V_LSB +: COORD_W]   = it.v;
        return d;
    endfunction

    function automatic logic [VALUE_W-1:0] rand_height();
        int t;
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2:
            begin
                t = $urandom_range(0, 2000);
                return t - 1000;
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 17'd65536;
            2: return $urandom_range(65537, 131071);
            3: return $urandom_range(0, 512);
            4: return 17'd65536 - $urandom_range(0, 512);
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    task automatic queue_write(input logic [INDEX_W-1:0] idx, input logic [VALUE_W-1:0] val);
        hbs_item_t it;
        it.cmd = CMD_WRITE;
        it.idx = idx;
        it.val = val;
        it.u = $urandom_range(0, 131071);
        it.v = $urandom_range(0, 131071);
        item_backlog.push_back(it);
        loaded_texels[idx] = 1'b1;
        queued_total++;
    endtask

    // Load any corner not yet written, then queue the sample itself.
    task automatic queue_sample(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v);
        logic [3:0][INDEX_W-1:0] at;
        int unsigned sx, sy;
        hbs_item_t it;
        locate_corners(u, v, at, sx, sy);
        for (int k = 0; k < 4; k++)
            if (!loaded_texels[at[k]])
                queue_write(at[k], rand_height());
        it.cmd = CMD_SAMPLE;
        it.idx = $urandom;
        it.val = $urandom;
        it.u = u;
        it.v = v;
        item_backlog.push_back(it);
        queued_total++;
    endtask

    task automatic run_random(input int n);
        int start;
        start = queued_total;
        while (queued_total - start < n)
        begin
            if ($urandom_range(0, 99) < 12)
                queue_write($urandom, rand_height());
            else
                queue_sample(rand_coord(), rand_coord());
        end
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (item_backlog.size() != 0 || s_tvalid || expected_heights.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_dims(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= CFG_MAP_WIDTH;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_addr <= CFG_MAP_HEIGHT;
        cfg_wdata <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_width = w;
        cur_height = h;
        dim_settings++;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                             input int n, input bit idle);
        send_idle_on = idle;
        recv_idle_on = idle;
        set_dims(w, h);
        run_random(n);
        drain();
    endtask

    // Driver: advance to the next pending item once the current one is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= CMD_WRITE;
            send_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (offered_item.cmd == CMD_WRITE)
                begin
                    height_mirror[offered_item.idx] = offered_item.val;
                    writes_seen++;
                end
                else
                begin
                    expected_heights.push_back(bilerp_height(offered_item.u, offered_item.v));
                    samples_seen++;
                end
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (item_backlog.size() > 0)
                begin
                    offered_item = item_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= pack_item(offered_item);
                    s_tuser <= offered_item.cmd;
                    if (send_idle_on && $urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 18);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: check each result item, then decide whether to stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_heights.size() == 0)
                begin
                    $error("height_result with no sample pending: got %h", m_tdata);
                    error_count++;
                end
                else
                begin
                    logic [OUT_W-1:0] want;
                    want = expected_heights.pop_front();
                    results_checked++;
                    if (m_tdata !== want)
                    begin
                        $error("height_result mismatch: expected %h, got %h", want, m_tdata);
                        error_count++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (long_hold_seen != long_hold_ask)
            begin
                long_hold_seen = long_hold_ask;
                hold_left = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end
            else if (recv_idle_on && $urandom_range(0, 9) == 0)
            begin
                hold_left = $urandom_range(0, 17);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset dimensions 256 x 256: extreme heights, both edges, coordinates above 1.0.
        queue_write(16'd0, 32'h7FFF_FFFF);
        queue_write(16'd1, 32'h8000_0000);
        queue_write(16'd256, 32'h8000_0000);
        queue_write(16'd257, 32'h7FFF_FFFF);
        queue_write(16'd65535, 32'hFFFF_FFFF);
        queue_write(16'd65534, 32'h0000_0000);
        queue_sample(17'd0, 17'd0);
        queue_sample(17'd256, 17'd256);
        queue_sample(17'd384, 17'd128);
        queue_sample(17'd65536, 17'd65536);
        queue_sample(17'd131071, 17'd131071);
        queue_sample(17'd65535, 17'd0);
        queue_sample(17'd0, 17'd65536);
        queue_sample(17'd65408, 17'd65408);
        drain();

        run_phase(11'd1, 11'd1, 60, 1'b1);
        run_phase(11'd4, 11'd3, 150, 1'b1);
        run_phase(11'd1024, 11'd1024, 200, 1'b1);
        run_phase(11'd0, 11'd2047, 100, 1'b1);
        run_phase(11'd2047, 11'd0, 100, 1'b1);

        // Hold the output long enough to back up the block while items keep coming.
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        set_dims(11'd5, 11'd7);
        long_hold_ask++;
        run_random(250);
        drain();

        for (int p = 0; p < 4; p++)
            run_phase($urandom_range(1, 40), $urandom_range(1, 40), 130, p[0]);
        run_phase(11'd1000, 11'd2, 120, 1'b1);
        run_phase(11'd16, 11'd16, 200, 1'b0);

        if (expected_heights.size() != 0)
        begin
            $error("%0d expected heights never arrived", expected_heights.size());
            error_count++;
        end
        $display("Covered %0d height writes and %0d samples over %0d map sizes,",
                 writes_seen, samples_seen, dim_settings);
        $display("including edge clamps, out-of-range sizes and a long output stall.");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
